@@ rtl/core/cpd_pkg.sv @@
// Shared constants and types for the credit-based packet dropper.
`timescale 1ns / 1ps
package cpd_pkg;

   localparam int DEF_BUFFER_DEPTH = 2048;
   localparam int DEF_WORD_BITS    = 64;

   localparam int THRESH_W    = 12;
   localparam int COUNT_W     = 32;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_DROP_THRESHOLD = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_LENGTH  = CSR_INDEX_W'(1);

   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(64);
   localparam logic [COUNT_W-1:0]  WINDOW_RESET = COUNT_W'(1048576);

   // Where the word of one transfer is sent.
   typedef struct packed {
      logic fwd;
      logic ovf;
   } route_type;

endpackage

@@ rtl/core/cpd_drop_ctl.sv @@
// Credit tracking, whole-packet drop decision and packet counters.
`timescale 1ns / 1ps
module cpd_drop_ctl
   import cpd_pkg::*;
#(
   parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                word_valid,
   input  logic                end_of_packet,
   input  logic                credit_return,
   input  logic [THRESH_W-1:0] drop_threshold,
   output route_type           route,
   output logic [COUNT_W-1:0]  dropped_packets,
   output logic [COUNT_W-1:0]  total_packets
);

   localparam int CREDIT_W = $clog2(BUFFER_DEPTH + 1);
   localparam int CMP_W    = (CREDIT_W > THRESH_W) ? CREDIT_W : THRESH_W;
   localparam logic [CREDIT_W-1:0] CREDIT_MAX = CREDIT_W'(BUFFER_DEPTH);

   logic [CREDIT_W-1:0] credit_ff, credit_in;
   logic                dropping_ff, dropping_in;
   logic                pending_ff, pending_in;
   logic                start_ff, start_in;
   logic [COUNT_W-1:0]  dropped_ff, dropped_in;
   logic [COUNT_W-1:0]  total_ff, total_in;
   logic                drop_now;
   logic                pkt_end;

   // The decision taken at the first word holds for the rest of the packet.
   assign drop_now  = start_ff ? pending_ff : dropping_ff;
   assign route.fwd = word_valid && !drop_now;
   assign route.ovf = word_valid && drop_now;
   assign pkt_end   = word_valid && end_of_packet;

   always_comb begin
      credit_in   = credit_ff;
      dropping_in = dropping_ff;
      start_in    = start_ff;
      dropped_in  = dropped_ff;
      total_in    = total_ff;
      pending_in  = pending_ff;
      if (step) begin
         if (word_valid) begin
            dropping_in = drop_now;
            start_in    = end_of_packet;
         end
         if (pkt_end) begin
            total_in = total_ff + COUNT_W'(1);
            if (drop_now) begin
               dropped_in = dropped_ff + COUNT_W'(1);
            end
         end
         // Uses the credit level from before this transfer's change.
         pending_in = CMP_W'(credit_ff) < CMP_W'(drop_threshold);
         if (route.fwd && !credit_return) begin
            if (credit_ff != '0) begin
               credit_in = credit_ff - CREDIT_W'(1);
            end
         end else if (credit_return && !route.fwd) begin
            if (credit_ff < CREDIT_MAX) begin
               credit_in = credit_ff + CREDIT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff   <= CREDIT_MAX;
         dropping_ff <= 1'b0;
         pending_ff  <= 1'b0;
         start_ff    <= 1'b1;
         dropped_ff  <= '0;
         total_ff    <= '0;
      end else begin
         credit_ff   <= credit_in;
         dropping_ff <= dropping_in;
         pending_ff  <= pending_in;
         start_ff    <= start_in;
         dropped_ff  <= dropped_in;
         total_ff    <= total_in;
      end
   end

   assign dropped_packets = dropped_ff;
   assign total_packets   = total_ff;

endmodule

@@ rtl/core/cpd_window.sv @@
// Measurement window: busy-tick accumulators latched at each window end.
`timescale 1ns / 1ps
module cpd_window
   import cpd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic               word_valid,
   input  logic               fwd,
   input  logic [COUNT_W-1:0] window_length,
   output logic [COUNT_W-1:0] in_busy_ticks,
   output logic [COUNT_W-1:0] out_busy_ticks
);

   logic [COUNT_W-1:0] tick_ff, tick_in;
   logic [COUNT_W-1:0] in_acc_ff, in_acc_in;
   logic [COUNT_W-1:0] out_acc_ff, out_acc_in;
   logic [COUNT_W-1:0] in_lat_ff, in_lat_in;
   logic [COUNT_W-1:0] out_lat_ff, out_lat_in;
   logic [COUNT_W:0]   tick_plus;
   logic               wrap;
   logic [COUNT_W-1:0] in_sum;
   logic [COUNT_W-1:0] out_sum;

   // A window length of zero therefore ends the window on every tick.
   assign tick_plus = {1'b0, tick_ff} + (COUNT_W + 1)'(1);
   assign wrap      = tick_plus >= {1'b0, window_length};
   assign in_sum    = in_acc_ff + COUNT_W'(word_valid);
   assign out_sum   = out_acc_ff + COUNT_W'(fwd);

   always_comb begin
      tick_in    = tick_ff;
      in_acc_in  = in_acc_ff;
      out_acc_in = out_acc_ff;
      in_lat_in  = in_lat_ff;
      out_lat_in = out_lat_ff;
      if (step) begin
         if (wrap) begin
            tick_in    = '0;
            in_lat_in  = in_sum;
            out_lat_in = out_sum;
            in_acc_in  = '0;
            out_acc_in = '0;
         end else begin
            tick_in    = tick_plus[COUNT_W-1:0];
            in_acc_in  = in_sum;
            out_acc_in = out_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff    <= '0;
         in_acc_ff  <= '0;
         out_acc_ff <= '0;
         in_lat_ff  <= '0;
         out_lat_ff <= '0;
      end else begin
         tick_ff    <= tick_in;
         in_acc_ff  <= in_acc_in;
         out_acc_ff <= out_acc_in;
         in_lat_ff  <= in_lat_in;
         out_lat_ff <= out_lat_in;
      end
   end

   assign in_busy_ticks  = in_lat_ff;
   assign out_busy_ticks = out_lat_ff;

endmodule

@@ rtl/core/credit_packet_dropper.sv @@
// Top level of the credit-based whole-packet drop stage.
`timescale 1ns / 1ps
// Each transfer on the req_ channel is one tick: an optional payload word with its
// end-of-packet mark and an optional returned credit. The block takes one transfer
// per clock cycle while the output is not stalled and returns one rsp_ transfer for
// each, passing it through the input register and then the update logic ahead of
// the result register. Whole packets go to the main output, or to the overflow
// output when the credit level on the previous tick was below drop_threshold. The
// packet and busy-tick counters on the rsp_ channel show their values after that
// transfer's update. Registers are written through the csr_ channel (index 0
// drop_threshold, index 1 window_length, others ignored); csr_ready is always high.
// The user must write them only while the block is idle; the block does not check.
module credit_packet_dropper
   import cpd_pkg::*;
#(
   parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
   parameter int WORD_BITS    = DEF_WORD_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_word_valid,
   input  logic [WORD_BITS-1:0]   req_data_word,
   input  logic                   req_end_of_packet,
   input  logic                   req_credit_return,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_main_valid,
   output logic                   rsp_overflow_valid,
   output logic [WORD_BITS-1:0]   rsp_word_out,
   output logic                   rsp_eop_out,
   output logic [COUNT_W-1:0]     rsp_dropped_packets,
   output logic [COUNT_W-1:0]     rsp_total_packets,
   output logic [COUNT_W-1:0]     rsp_in_busy_ticks,
   output logic [COUNT_W-1:0]     rsp_out_busy_ticks,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [THRESH_W-1:0]  thresh_ff, thresh_in;
   logic [COUNT_W-1:0]   wlen_ff, wlen_in;

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_wvalid_ff;
   logic [WORD_BITS-1:0] s1_word_ff;
   logic                 s1_eop_ff;
   logic                 s1_credit_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   route_type            route_ff;
   logic [WORD_BITS-1:0] word_ff;
   logic                 eop_ff;

   logic                 advance;
   logic                 step;
   logic                 req_take;
   route_type            route;

   assign csr_ready = 1'b1;
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      thresh_in = thresh_ff;
      wlen_in   = wlen_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_DROP_THRESHOLD: thresh_in = csr_wdata[THRESH_W-1:0];
            REG_WINDOW_LENGTH:  wlen_in   = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= THRESH_RESET;
         wlen_ff      <= WINDOW_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thresh_ff    <= thresh_in;
         wlen_ff      <= wlen_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_wvalid_ff <= req_word_valid;
         s1_word_ff   <= req_data_word;
         s1_eop_ff    <= req_end_of_packet;
         s1_credit_ff <= req_credit_return;
      end
      if (step) begin
         route_ff <= route;
         word_ff  <= s1_wvalid_ff ? s1_word_ff : '0;
         eop_ff   <= s1_wvalid_ff && s1_eop_ff;
      end
   end

   cpd_drop_ctl #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_drop_ctl (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .word_valid     (s1_wvalid_ff),
      .end_of_packet  (s1_eop_ff),
      .credit_return  (s1_credit_ff),
      .drop_threshold (thresh_ff),
      .route          (route),
      .dropped_packets(rsp_dropped_packets),
      .total_packets  (rsp_total_packets)
   );

   cpd_window u_window (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .word_valid    (s1_wvalid_ff),
      .fwd           (route.fwd),
      .window_length (wlen_ff),
      .in_busy_ticks (rsp_in_busy_ticks),
      .out_busy_ticks(rsp_out_busy_ticks)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_main_valid     = route_ff.fwd;
   assign rsp_overflow_valid = route_ff.ovf;
   assign rsp_word_out       = word_ff;
   assign rsp_eop_out        = eop_ff;

endmodule

@@ rtl/core/cpd_checker.sv @@
// Port-level checks for the credit-based packet dropper, bound to the top level.
`timescale 1ns / 1ps
module cpd_checker
   import cpd_pkg::*;
#(
   parameter int WORD_BITS = DEF_WORD_BITS
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_main_valid,
   input logic                 rsp_overflow_valid,
   input logic [WORD_BITS-1:0] rsp_word_out,
   input logic                 rsp_eop_out,
   input logic [COUNT_W-1:0]   rsp_dropped_packets,
   input logic [COUNT_W-1:0]   rsp_total_packets
);

   // A stalled result keeps its main-output flag and total packet count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_main_valid) && $stable(rsp_total_packets))
      else $error("stalled result changed");

   // A word goes to at most one output.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_main_valid && rsp_overflow_valid))
      else $error("word routed to both outputs");

   // Without a word the payload is cleared.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_main_valid && !rsp_overflow_valid |->
         rsp_word_out == '0 && !rsp_eop_out)
      else $error("empty tick carries payload");

   // A dropped packet is always counted among all packets at the same transfer.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && rsp_dropped_packets != $past(rsp_dropped_packets) |->
         rsp_total_packets != $past(rsp_total_packets))
      else $error("drop counted without packet end");

endmodule

bind credit_packet_dropper cpd_checker #(.WORD_BITS(WORD_BITS)) u_cpd_checker (.*);
